[src/tig_pkg.sv]
package tig_pkg;

    localparam int INDEX_W         = 32;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 2;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int STEP_W          = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_WIDE = 1'b1;

    localparam logic [STEP_W-1:0] STEP_LAST_TRI  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_LAST_QUAD = 3'd5;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_STRIP = 2'd1,
        MODE_FAN   = 2'd2,
        MODE_QUADS = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_STRIP = 2'd0,
        KIND_FAN   = 2'd1,
        KIND_QUAD  = 2'd2
    } t_kind;

    // one vertex that completes a primitive
    typedef struct packed {
        t_kind               kind;
        logic                odd;
        logic                wide;
        logic [INDEX_W-1:0]  start;
        logic [INDEX_W-1:0]  sum;    // start + position
    } t_job;

endpackage

[src/triangle_index_generator.sv]
// Channel   Dir  Payload
// s (in)    in   tdata[31:0] draw_start, tlast vertex_last
// m (out)   out  tdata[31:0] index_value, tlast run_last
// cfg       in   we, index (0 index_mode, 1 wide_indices), data[1:0]
//
// One index per cycle leaves the output register while a job is queued and m
// tready is high: a strip or fan vertex yields 3 indices, a quad-completing vertex
// 6, others none. The front accepts a vertex each cycle while the job queue has
// room, so vertices that emit nothing pass at one per cycle. Reset is synchronous
// and needs no clearing time. Output stalls fill the queue, then drop s tready.
module triangle_index_generator
    import tig_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [INDEX_W-1:0]     i_s_tdata,   // [31:0] draw_start
    input  logic                   i_s_tlast,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [INDEX_W-1:0]     o_m_tdata,   // [31:0] index_value
    output logic                   o_m_tlast
);

    logic push;
    logic full;
    logic pop;
    logic head_valid;
    t_job push_job;
    t_job head_job;

    tig_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_full      (full),
        .o_push      (push),
        .o_job       (push_job)
    );

    tig_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    tig_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (head_valid),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

[src/tig_front.sv]
module tig_front
    import tig_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [INDEX_W-1:0]     i_s_tdata,
    input  logic                   i_s_tlast,
    input  logic                   i_full,
    output logic                   o_push,
    output t_job                   o_job
);

    t_mode               r_mode;
    logic                r_wide;
    logic [INDEX_W-1:0]  r_start;
    logic [INDEX_W-1:0]  r_pos;

    logic                accept;
    logic                first;
    logic [INDEX_W-1:0]  start;
    logic                emit;
    t_kind               kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
            r_wide <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INDEX_MODE: r_mode <= t_mode'(i_cfg_data[1:0]);
                CFG_INDEX_WIDE: r_wide <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_s_tready = !i_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign first      = (r_pos == '0);
    assign start      = first ? i_s_tdata : r_start;

    always_comb begin
        emit = 1'b0;
        kind = KIND_STRIP;
        unique case (r_mode)
            MODE_STRIP: begin
                emit = |r_pos[INDEX_W-1:1];
                kind = KIND_STRIP;
            end
            MODE_FAN: begin
                emit = |r_pos[INDEX_W-1:1];
                kind = KIND_FAN;
            end
            MODE_QUADS: begin
                emit = &r_pos[1:0];
                kind = KIND_QUAD;
            end
            default: ;
        endcase
    end

    // position p: strip parity of p - 2 equals that of p
    assign o_job.kind  = kind;
    assign o_job.odd   = r_pos[0];
    assign o_job.wide  = r_wide;
    assign o_job.start = start;
    assign o_job.sum   = start + r_pos;
    assign o_push      = accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= i_s_tlast ? '0 : r_pos + INDEX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && first) begin
            r_start <= i_s_tdata;
        end
    end

endmodule

[src/tig_queue.sv]
module tig_queue
    import tig_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[src/tig_back.sv]
module tig_back
    import tig_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [INDEX_W-1:0] o_m_tdata,
    output logic               o_m_tlast
);

    logic [STEP_W-1:0]  r_step;
    logic               r_valid;
    logic [INDEX_W-1:0] r_data;
    logic               r_last;

    logic [STEP_W-1:0]  last_step;
    logic               at_last;
    logic               load;
    logic               use_start;
    logic signed [2:0]  offset;
    logic [INDEX_W-1:0] base;
    logic [INDEX_W-1:0] value;

    assign last_step = (i_job.kind == KIND_QUAD) ? STEP_LAST_QUAD : STEP_LAST_TRI;
    assign at_last   = (r_step == last_step);
    assign load      = i_valid && (!r_valid || i_m_tready);
    assign o_pop     = load && at_last;

    // offsets relative to start + position; fan step 0 uses start itself
    always_comb begin
        use_start = 1'b0;
        offset    = 3'sd0;
        unique case (i_job.kind)
            KIND_STRIP: begin
                case (r_step)
                    3'd0:    offset = -3'sd2;
                    3'd1:    offset = i_job.odd ? 3'sd0 : -3'sd1;
                    default: offset = i_job.odd ? -3'sd1 : 3'sd0;
                endcase
            end
            KIND_FAN: begin
                case (r_step)
                    3'd0:    use_start = 1'b1;
                    3'd1:    offset = -3'sd1;
                    default: offset = 3'sd0;
                endcase
            end
            KIND_QUAD: begin
                case (r_step)
                    3'd0:    offset = -3'sd3;
                    3'd1:    offset = -3'sd2;
                    3'd2:    offset = -3'sd1;
                    3'd3:    offset = -3'sd1;
                    3'd4:    offset = -3'sd2;
                    default: offset = 3'sd0;
                endcase
            end
            default: ;
        endcase
    end

    assign base  = use_start ? i_job.start : i_job.sum;
    assign value = base + INDEX_W'(offset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_step  <= at_last ? '0 : r_step + STEP_W'(1);
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_job.wide ? value : {16'h0000, value[15:0]};
            r_last <= at_last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;

endmodule

[verif/triangle_index_generator_tb.sv]
module triangle_index_generator_tb;
    import tig_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 130;

    typedef struct packed {
        logic [INDEX_W-1:0] index_value;
        logic               run_last;
    } t_index_exp;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [INDEX_W-1:0]     i_s_tdata;   // [31:0] draw_start
    logic                   i_s_tlast;   // vertex_last
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [INDEX_W-1:0]     o_m_tdata;   // [31:0] index_value
    logic                   o_m_tlast;   // run_last

    t_index_exp         pending_indices[$];
    t_mode              cur_mode;
    logic               cur_wide;
    logic [INDEX_W-1:0] start_hold;
    logic [INDEX_W-1:0] vertex_pos;
    int                 errors;
    int                 quiet_cycles;
    int                 ready_stall;
    bit                 bursts_on;

    triangle_index_generator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic logic [INDEX_W-1:0] fit_width(input logic [INDEX_W-1:0] v);
        return cur_wide ? v : {16'h0000, v[15:0]};
    endfunction

    task automatic push_index(input logic [INDEX_W-1:0] v, input logic last);
        t_index_exp e;
        e.index_value = fit_width(v);
        e.run_last    = last;
        pending_indices.push_back(e);
    endtask

    task automatic predict_vertex(input logic [INDEX_W-1:0] start, input logic last);
        logic [INDEX_W-1:0] p;
        logic [INDEX_W-1:0] s;
        logic [INDEX_W-1:0] t;
        logic [INDEX_W-1:0] base;
        logic [INDEX_W-1:0] odd;
        p = vertex_pos;
        if (p == 0) begin
            start_hold = start;
        end
        s = start_hold;
        case (cur_mode)
            MODE_STRIP: begin
                if (p >= 2) begin
                    t   = p - 2;
                    odd = {31'b0, t[0]};
                    push_index(s + t, 1'b0);
                    push_index(s + t + 1 + odd, 1'b0);
                    push_index(s + t + 2 - odd, 1'b1);
                end
            end
            MODE_FAN: begin
                if (p >= 2) begin
                    push_index(s, 1'b0);
                    push_index(s + p - 1, 1'b0);
                    push_index(s + p, 1'b1);
                end
            end
            MODE_QUADS: begin
                if (p[1:0] == 2'b11) begin
                    base = s + p - 3;
                    push_index(base, 1'b0);
                    push_index(base + 1, 1'b0);
                    push_index(base + 2, 1'b0);
                    push_index(base + 2, 1'b0);
                    push_index(base + 1, 1'b0);
                    push_index(base + 3, 1'b1);
                end
            end
            default: begin
            end
        endcase
        vertex_pos = last ? '0 : p + 1;
    endtask

    // valid stays high after acceptance; the next call keeps or drops it
    task automatic send_vertex(input logic [INDEX_W-1:0] start, input logic last);
        int gap;
        @(negedge i_clk);
        if (bursts_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= start;
        i_s_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        predict_vertex(start, last);
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_indices.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_INDEX_MODE) begin
            cur_mode = t_mode'(data);
        end else begin
            cur_wide = data[0];
        end
    endtask

    task automatic send_draw(input logic [INDEX_W-1:0] start, input int len);
        for (int i = 0; i < len; i++) begin
            send_vertex(start, i == len - 1);
        end
    endtask

    task automatic test_mode_none_after_reset();
        send_draw(32'hFFFF_FFFF, 4);
        send_draw(32'h0000_0000, 1);
    endtask

    task automatic test_strip_draws();
        write_register(CFG_INDEX_MODE, MODE_STRIP);
        send_draw(32'd5, 2);
        // crosses the 16-bit boundary
        send_draw(32'h1234_FFFE, 4);
    endtask

    task automatic test_fan_draws();
        write_register(CFG_INDEX_WIDE, 2'd1);
        write_register(CFG_INDEX_MODE, MODE_FAN);
        send_draw(32'hFFFF_FFFE, 4);
    endtask

    task automatic test_quad_draws();
        write_register(CFG_INDEX_MODE, MODE_QUADS);
        send_draw(32'hFFFF_FFFC, 4);
        write_register(CFG_INDEX_WIDE, 2'd0);
        // partial quad
        send_draw(32'h0001_FFFD, 3);
    endtask

    task automatic test_mode_change_mid_draw();
        write_register(CFG_INDEX_MODE, MODE_STRIP);
        send_vertex(32'h0000_0100, 1'b0);
        send_vertex(32'h0000_0100, 1'b0);
        send_vertex(32'h0000_0100, 1'b0);
        write_register(CFG_INDEX_MODE, MODE_FAN);
        send_vertex(32'hAAAA_5555, 1'b0);
        write_register(CFG_INDEX_MODE, MODE_QUADS);
        send_vertex(32'h5555_AAAA, 1'b1);
    endtask

    function automatic logic [INDEX_W-1:0] pick_start();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return {16'($urandom_range(0, 65535)), 16'h0000} | 32'h0000_FFF0
                      | $urandom_range(0, 15);
            2: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
            default: return $urandom_range(0, 63);
        endcase
    endfunction

    task automatic test_random_draws();
        int sent;
        int left;
        int phase;
        int in_phase;
        logic [INDEX_W-1:0] start;
        sent  = 0;
        left  = 0;
        phase = 0;
        start = '0;
        while (sent < RANDOM_ITEMS) begin
            if (phase == 4) begin
                write_register(CFG_INDEX_MODE, MODE_NONE);
            end else begin
                write_register(CFG_INDEX_MODE, t_mode'(1 + phase % 3));
            end
            write_register(CFG_INDEX_WIDE, {1'b0, 1'($urandom_range(0, 1))});
            if (sent >= RANDOM_ITEMS - 45) begin
                bursts_on = 1'b0;
            end
            in_phase = (phase == 4) ? 6 : 23;
            for (int i = 0; i < in_phase; i++) begin
                if (left == 0) begin
                    left  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2)
                                                        : $urandom_range(3, 12);
                    start = pick_start();
                end
                if (phase == 2 && i == 10) begin
                    wait_results_done();
                end
                send_vertex(($urandom_range(0, 1) == 0) ? start : $urandom, left == 1);
                left--;
                if (phase != 4) begin
                    sent++;
                end
            end
            phase++;
        end
        while (left > 0) begin
            send_vertex($urandom, left == 1);
            left--;
        end
    endtask

    // receiver stalls in bursts
    always @(negedge i_clk) begin
        if (!bursts_on) begin
            ready_stall <= 0;
            i_m_tready  <= 1'b1;
        end else if (ready_stall > 0) begin
            ready_stall <= ready_stall - 1;
            i_m_tready  <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            ready_stall <= $urandom_range(0, 18);
            i_m_tready  <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_index_exp e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_indices.size() == 0) begin
                $display("%0t unexpected index: expected none actual %h last %0b",
                         $time, o_m_tdata, o_m_tlast);
                errors++;
            end else begin
                e = pending_indices.pop_front();
                if (o_m_tdata !== e.index_value) begin
                    $display("%0t index_value: expected %h actual %h",
                             $time, e.index_value, o_m_tdata);
                    errors++;
                end
                if (o_m_tlast !== e.run_last) begin
                    $display("%0t run_last: expected %0b actual %0b",
                             $time, e.run_last, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_INDEX_MODE;
        i_cfg_data   = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tlast    = 1'b0;
        i_m_tready   = 1'b0;
        ready_stall  = 0;
        quiet_cycles = 0;
        errors       = 0;
        bursts_on    = 1'b1;
        cur_mode     = MODE_NONE;
        cur_wide     = 1'b0;
        start_hold   = '0;
        vertex_pos   = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_mode_none_after_reset();
        test_strip_draws();
        test_fan_draws();
        test_quad_draws();
        test_mode_change_mid_draw();
        test_random_draws();

        wait_results_done();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
